/* design/otp_pkg.sv */
package otp_pkg;

    // fixed field widths on the stream ports
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int ID_IO_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int REASON_W  = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int ID_WIDTH_DEF   = 16;

    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 16'd42;

    localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam logic [REASON_W-1:0] RSN_OLDEST    = 2'd0;
    localparam logic [REASON_W-1:0] RSN_REQUESTED = 2'd1;
    localparam logic [REASON_W-1:0] RSN_IRQ       = 2'd2;
    localparam logic [REASON_W-1:0] RSN_IDLE      = 2'd3;

    // write strobes into the slot table
    typedef struct packed {
        logic wr;
        logic mark;
        logic stamp;
        logic clr_fresh;
    } t_tbl_ctl;

endpackage

/* design/otp_age_cmp.sv */
module otp_age_cmp
    import otp_pkg::*;
(
    input  logic [STAMP_W-1:0] i_tick,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [STAMP_W-1:0] i_best,
    output logic [STAMP_W-1:0] o_age,
    output logic               o_older
);

    // age wraps modulo 2^32, zero age never wins since best starts at zero
    assign o_age   = i_tick - i_stamp;
    assign o_older = o_age > i_best;

endmodule

/* design/otp_slot_table.sv */
module otp_slot_table
    import otp_pkg::*;
#(
    parameter  int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter  int ID_WIDTH   = ID_WIDTH_DEF,
    localparam int SLOT_W     = $clog2(SLOT_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tbl_ctl            i_ctl,
    input  logic [SLOT_W-1:0]   i_wr_idx,
    input  logic [ID_WIDTH-1:0] i_wr_id,
    input  logic                i_wr_used,
    input  logic                i_wr_active,
    input  logic                i_wr_irq,
    input  logic [STAMP_W-1:0]  i_wr_stamp,
    input  logic [SLOT_W-1:0]   i_stamp_idx,
    input  logic [STAMP_W-1:0]  i_stamp_val,
    input  logic [SLOT_W-1:0]   i_clr_idx,
    input  logic [SLOT_W-1:0]   i_rd_idx,
    output logic [ID_WIDTH-1:0] o_rd_id,
    output logic [STAMP_W-1:0]  o_rd_stamp,
    output logic                o_rd_elig,
    output logic                o_rd_irq
);

    logic [ID_WIDTH-1:0] r_id_mem    [SLOT_COUNT];
    logic [STAMP_W-1:0]  r_stamp_mem [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_active;
    logic [SLOT_COUNT-1:0] r_irq;
    logic [SLOT_COUNT-1:0] r_fresh;

    logic [ID_WIDTH-1:0] r_rd_id;
    logic [STAMP_W-1:0]  r_rd_stamp;
    logic                r_rd_elig;
    logic                r_rd_irq;

    logic                w_st_en;
    logic [SLOT_W-1:0]   w_st_idx;
    logic [STAMP_W-1:0]  w_st_val;

    // stamping and slot writes never fall in the same cycle, so one port
    assign w_st_en  = i_ctl.stamp | i_ctl.wr;
    assign w_st_idx = i_ctl.stamp ? i_stamp_idx : i_wr_idx;
    assign w_st_val = i_ctl.stamp ? i_stamp_val : i_wr_stamp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_id_mem[i_wr_idx] <= i_wr_id;
        end
        if (w_st_en) begin
            r_stamp_mem[w_st_idx] <= w_st_val;
        end
        r_rd_id    <= r_id_mem[i_rd_idx];
        r_rd_stamp <= r_stamp_mem[i_rd_idx];
        r_rd_elig  <= r_used[i_rd_idx] & r_active[i_rd_idx];
        r_rd_irq   <= r_irq[i_rd_idx] & r_fresh[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_active <= '0;
            r_irq    <= '0;
            r_fresh  <= '0;
        end else begin
            if (i_ctl.wr) begin
                r_used[i_wr_idx]   <= i_wr_used;
                r_active[i_wr_idx] <= i_wr_active;
                r_irq[i_wr_idx]    <= i_wr_irq;
                r_fresh[i_wr_idx]  <= 1'b0;
            end
            if (i_ctl.mark) begin
                r_fresh[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.clr_fresh) begin
                r_fresh[i_clr_idx] <= 1'b0;
            end
        end
    end

    assign o_rd_id    = r_rd_id;
    assign o_rd_stamp = r_rd_stamp;
    assign o_rd_elig  = r_rd_elig;
    assign o_rd_irq   = r_rd_irq;

endmodule

/* design/oldest_first_task_picker_top.sv */
// Oldest-first task picker. Write and interrupt-mark requests update the slot
// table in the cycle they are accepted and return nothing. After a schedule
// request is accepted, a stamp step first stamps the running slot (unless the
// last pick was idle) and advances the tick; the single age subtract-and-compare
// unit walks the table one slot per cycle through its one registered read
// port, which is drained before the final step makes the decision and loads
// the output register. The input is ready only while no schedule is in
// progress, and the decision waits while an earlier result is still held; a
// finished result waits in the output register without blocking further
// write or mark requests. A schedule result picks the last fresh interrupt
// handler, else the requested id when the greatest age is below age_limit,
// else the first slot of greatest age; idle when no used and active slot has
// a nonzero age.
module oldest_first_task_picker_top
    import otp_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,     // age_limit
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // requested_id[15:0], slot_index[19:16], task_id[35:20], slot_used[36],
    // is_active[37], handles_irq[38], start_stamp[70:39], zero[71]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [OP_W-1:0]      i_s_axis_tuser,  // operation
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // chosen_slot[3:0], chosen_id[19:4], zero[23:20]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic [REASON_W-1:0]  o_m_axis_tuser   // pick_reason
);

    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int SLOT_EXT_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam int ID_EXT_W   = (ID_WIDTH > ID_IO_W) ? ID_WIDTH : ID_IO_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STAMP = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // request fields
    logic [ID_IO_W-1:0] w_req_id_in;
    logic [IDX_W-1:0]   w_slot_index;
    logic [ID_IO_W-1:0] w_task_id;
    logic               w_slot_used;
    logic               w_is_active;
    logic               w_handles_irq;
    logic [STAMP_W-1:0] w_start_stamp;

    logic [SLOT_EXT_W-1:0] w_idx_ext;
    logic [SLOT_W-1:0]     w_idx;
    logic                  w_idx_ok;
    logic [ID_EXT_W-1:0]   w_task_ext;
    logic [ID_EXT_W-1:0]   w_want_ext;

    logic w_in_acc;
    logic w_issue;
    logic w_hit;
    logic w_done_fire;

    logic [1:0]          r_state;
    logic [STAMP_W-1:0]  r_tick;
    logic [SLOT_W-1:0]   r_run_slot;
    logic                r_run_idle;
    logic [LIMIT_W-1:0]  r_limit;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ev_valid;
    logic                r_have_old;
    logic                r_have_req;
    logic                r_have_irq;
    logic                r_out_valid;

    logic [ID_WIDTH-1:0] r_want;
    logic [SLOT_W-1:0]   r_ev_idx;
    logic [STAMP_W-1:0]  r_best;
    logic [SLOT_W-1:0]   r_old_idx;
    logic [ID_WIDTH-1:0] r_old_id;
    logic [SLOT_W-1:0]   r_req_idx;
    logic [ID_WIDTH-1:0] r_req_id;
    logic [SLOT_W-1:0]   r_irq_idx;
    logic [ID_WIDTH-1:0] r_irq_id;
    logic [IDX_W-1:0]    r_out_slot;
    logic [ID_IO_W-1:0]  r_out_id;
    logic [REASON_W-1:0] r_out_reason;

    t_tbl_ctl            w_ctl;
    logic [ID_WIDTH-1:0] w_rd_id;
    logic [STAMP_W-1:0]  w_rd_stamp;
    logic                w_rd_elig;
    logic                w_rd_irq;
    logic [STAMP_W-1:0]  w_age;
    logic                w_older;

    logic [SLOT_W-1:0]     w_pick_idx;
    logic [ID_WIDTH-1:0]   w_pick_id;
    logic [REASON_W-1:0]   w_reason;
    logic [SLOT_EXT_W-1:0] w_pick_ext;
    logic [ID_EXT_W-1:0]   w_pick_id_ext;

    assign w_req_id_in   = i_s_axis_tdata[15:0];
    assign w_slot_index  = i_s_axis_tdata[19:16];
    assign w_task_id     = i_s_axis_tdata[35:20];
    assign w_slot_used   = i_s_axis_tdata[36];
    assign w_is_active   = i_s_axis_tdata[37];
    assign w_handles_irq = i_s_axis_tdata[38];
    assign w_start_stamp = i_s_axis_tdata[70:39];

    assign w_idx_ext  = SLOT_EXT_W'(w_slot_index);
    assign w_idx      = w_idx_ext[SLOT_W-1:0];
    assign w_idx_ok   = 32'(w_slot_index) < SLOT_COUNT;
    assign w_task_ext = ID_EXT_W'(w_task_id);
    assign w_want_ext = ID_EXT_W'(w_req_id_in);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    assign w_issue     = (r_state == ST_SCAN) && (r_cnt < CNT_W'(SLOT_COUNT));
    assign w_hit       = r_ev_valid & w_rd_elig;
    assign w_done_fire = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_ctl           = '0;
        w_ctl.wr        = w_in_acc && (i_s_axis_tuser == OP_WRITE) && w_idx_ok;
        w_ctl.mark      = w_in_acc && (i_s_axis_tuser == OP_MARK) && w_idx_ok;
        w_ctl.stamp     = (r_state == ST_STAMP) && !r_run_idle;
        w_ctl.clr_fresh = w_done_fire && r_have_old && r_have_irq;
    end

    otp_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_WIDTH   (ID_WIDTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_idx    (w_idx),
        .i_wr_id     (w_task_ext[ID_WIDTH-1:0]),
        .i_wr_used   (w_slot_used),
        .i_wr_active (w_is_active),
        .i_wr_irq    (w_handles_irq),
        .i_wr_stamp  (w_start_stamp),
        .i_stamp_idx (r_run_slot),
        .i_stamp_val (r_tick),
        .i_clr_idx   (r_irq_idx),
        .i_rd_idx    (r_cnt[SLOT_W-1:0]),
        .o_rd_id     (w_rd_id),
        .o_rd_stamp  (w_rd_stamp),
        .o_rd_elig   (w_rd_elig),
        .o_rd_irq    (w_rd_irq)
    );

    otp_age_cmp u_age (
        .i_tick  (r_tick),
        .i_stamp (w_rd_stamp),
        .i_best  (r_best),
        .o_age   (w_age),
        .o_older (w_older)
    );

    // priority: idle when no slot has a nonzero age, then fresh interrupt handler, then requested id, then oldest
    always_comb begin
        priority if (!r_have_old) begin
            w_pick_idx = '0;
            w_pick_id  = '0;
            w_reason   = RSN_IDLE;
        end else if (r_have_irq) begin
            w_pick_idx = r_irq_idx;
            w_pick_id  = r_irq_id;
            w_reason   = RSN_IRQ;
        end else if (r_have_req && (r_best < STAMP_W'(r_limit))) begin
            w_pick_idx = r_req_idx;
            w_pick_id  = r_req_id;
            w_reason   = RSN_REQUESTED;
        end else begin
            w_pick_idx = r_old_idx;
            w_pick_id  = r_old_id;
            w_reason   = RSN_OLDEST;
        end
    end

    assign w_pick_ext    = SLOT_EXT_W'(w_pick_idx);
    assign w_pick_id_ext = ID_EXT_W'(w_pick_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_run_slot  <= '0;
            r_run_idle  <= 1'b1;
            r_limit     <= AGE_LIMIT_RESET;
            r_cnt       <= '0;
            r_ev_valid  <= 1'b0;
            r_have_old  <= 1'b0;
            r_have_req  <= 1'b0;
            r_have_irq  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            // a new result may replace one taken in the same cycle
            if (w_done_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_s_axis_tuser == OP_SCHED)) begin
                        r_state <= ST_STAMP;
                    end
                end
                ST_STAMP: begin
                    r_tick     <= r_tick + 1'b1;
                    r_cnt      <= '0;
                    r_ev_valid <= 1'b0;
                    r_have_old <= 1'b0;
                    r_have_req <= 1'b0;
                    r_have_irq <= 1'b0;
                    r_state    <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_ev_valid <= w_issue;
                    if (w_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                    if (w_hit && w_older) begin
                        r_have_old <= 1'b1;
                    end
                    if (w_hit && (w_rd_id == r_want)) begin
                        r_have_req <= 1'b1;
                    end
                    if (w_hit && w_rd_irq) begin
                        r_have_irq <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_done_fire) begin
                        r_run_idle  <= !r_have_old;
                        r_run_slot  <= w_pick_idx;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_want <= w_want_ext[ID_WIDTH-1:0];
        end
        if (r_state == ST_STAMP) begin
            r_best <= '0;
        end
        if (w_issue) begin
            r_ev_idx <= r_cnt[SLOT_W-1:0];
        end
        if ((r_state == ST_SCAN) && w_hit) begin
            if (w_older) begin
                r_best    <= w_age;
                r_old_idx <= r_ev_idx;
                r_old_id  <= w_rd_id;
            end
            // later matches overwrite earlier ones
            if (w_rd_id == r_want) begin
                r_req_idx <= r_ev_idx;
                r_req_id  <= w_rd_id;
            end
            if (w_rd_irq) begin
                r_irq_idx <= r_ev_idx;
                r_irq_id  <= w_rd_id;
            end
        end
        if (w_done_fire) begin
            r_out_slot   <= w_pick_ext[IDX_W-1:0];
            r_out_id     <= w_pick_id_ext[ID_IO_W-1:0];
            r_out_reason <= w_reason;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out_id, r_out_slot};
    assign o_m_axis_tuser  = r_out_reason;

endmodule

/* dv/otp_pick_checker.sv */
module otp_pick_checker
    import otp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [OP_W-1:0]      i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic [REASON_W-1:0]  i_m_tuser,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_oldest_picks,
    output int                   o_requested_picks,
    output int                   o_irq_picks,
    output int                   o_idle_picks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic [ID_IO_W-1:0]  id;
        logic [REASON_W-1:0] reason;
    } t_pick;

    logic                slot_used    [SLOTS];
    logic                slot_active  [SLOTS];
    logic [ID_IO_W-1:0]  slot_id      [SLOTS];
    logic                slot_handler [SLOTS];
    logic                slot_fresh   [SLOTS];
    logic [STAMP_W-1:0]  slot_stamp   [SLOTS];
    logic [STAMP_W-1:0]  tick;
    logic [IDX_W-1:0]    run_slot;
    logic                run_idle;
    logic [LIMIT_W-1:0]  age_limit_q;

    t_pick pending_picks[$];

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_checked         = 0;
        o_oldest_picks    = 0;
        o_requested_picks = 0;
        o_irq_picks       = 0;
        o_idle_picks      = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_pick predict_pick(input logic [ID_IO_W-1:0] want);
        logic [STAMP_W-1:0] best_age;
        logic [STAMP_W-1:0] age;
        int                 oldest;
        int                 req;
        int                 irq;
        t_pick              p;
        // the running slot gets stamped even if it was rewritten since
        if (!run_idle) begin
            slot_stamp[run_slot] = tick;
        end
        tick     = tick + 1;
        best_age = '0;
        oldest   = -1;
        req      = -1;
        irq      = -1;
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_active[s]) begin
                if (slot_id[s] == want) req = s;
                if (slot_handler[s] && slot_fresh[s]) irq = s;
                age = tick - slot_stamp[s];
                if (age > best_age) begin
                    best_age = age;
                    oldest   = s;
                end
            end
        end
        // no slot with nonzero age: idle wins over request and interrupt
        if (oldest < 0) begin
            run_idle = 1'b1;
            run_slot = '0;
            p.slot   = '0;
            p.id     = '0;
            p.reason = RSN_IDLE;
            return p;
        end
        p.slot   = IDX_W'(oldest);
        p.reason = RSN_OLDEST;
        if (req >= 0 && best_age < STAMP_W'(age_limit_q)) begin
            p.slot   = IDX_W'(req);
            p.reason = RSN_REQUESTED;
        end
        if (irq >= 0) begin
            slot_fresh[irq] = 1'b0;
            p.slot          = IDX_W'(irq);
            p.reason        = RSN_IRQ;
        end
        p.id     = slot_id[p.slot];
        run_idle = 1'b0;
        run_slot = p.slot;
        return p;
    endfunction

    task automatic apply_request(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] d);
        logic [IDX_W-1:0] idx;
        idx = d[19:16];
        case (op)
            OP_SCHED: begin
                pending_picks.push_back(predict_pick(d[15:0]));
            end
            OP_WRITE: begin
                slot_id[idx]      = d[35:20];
                slot_used[idx]    = d[36];
                slot_active[idx]  = d[37];
                slot_handler[idx] = d[38];
                slot_fresh[idx]   = 1'b0;
                slot_stamp[idx]   = d[70:39];
            end
            OP_MARK: begin
                slot_fresh[idx] = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] d, input logic [REASON_W-1:0] rsn);
        t_pick exp_pick;
        if (pending_picks.size() == 0) begin
            report_mismatch($sformatf("result slot %0d id %h reason %0d with no schedule pending",
                                      d[3:0], d[19:4], rsn));
            return;
        end
        exp_pick = pending_picks.pop_front();
        o_checked++;
        case (exp_pick.reason)
            RSN_OLDEST:    o_oldest_picks++;
            RSN_REQUESTED: o_requested_picks++;
            RSN_IRQ:       o_irq_picks++;
            default:       o_idle_picks++;
        endcase
        if (d[3:0] !== exp_pick.slot) begin
            report_mismatch($sformatf("chosen_slot exp %0d got %0d", exp_pick.slot, d[3:0]));
        end
        if (d[19:4] !== exp_pick.id) begin
            report_mismatch($sformatf("chosen_id exp %h got %h", exp_pick.id, d[19:4]));
        end
        if (rsn !== exp_pick.reason) begin
            report_mismatch($sformatf("pick_reason exp %0d got %0d", exp_pick.reason, rsn));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_used[s]    = 1'b0;
                slot_active[s]  = 1'b0;
                slot_id[s]      = '0;
                slot_handler[s] = 1'b0;
                slot_fresh[s]   = 1'b0;
                slot_stamp[s]   = '0;
            end
            tick        = '0;
            run_slot    = '0;
            run_idle    = 1'b1;
            age_limit_q = AGE_LIMIT_RESET;
            pending_picks.delete();
        end else begin
            if (i_cfg_we) age_limit_q = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata, i_m_tuser);
            if (i_s_tvalid && i_s_tready) apply_request(i_s_tuser, i_s_tdata);
        end
        o_pending = pending_picks.size();
    end

endmodule

/* dv/tb_oldest_first_task_picker_top.sv */
module tb_oldest_first_task_picker_top;
    import otp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = SLOT_COUNT_DEF + 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int PHASES        = 5;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic [OP_W-1:0]      i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [REASON_W-1:0]  o_m_axis_tuser;

    int fail_count, pending, checked;
    int oldest_picks, requested_picks, irq_picks, idle_picks;

    int                 src_idle_pct  = 17;
    int                 sink_idle_pct = 17;
    int                 sched_count   = 0;
    int                 items_sent    = 0;
    logic [LIMIT_W-1:0] cur_limit     = AGE_LIMIT_RESET;
    logic [ID_IO_W-1:0] id_seen [SLOT_COUNT_DEF];

    always #5 i_clk = ~i_clk;

    oldest_first_task_picker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    otp_pick_checker pick_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_s_tvalid        (i_s_axis_tvalid),
        .i_s_tready        (o_s_axis_tready),
        .i_s_tdata         (i_s_axis_tdata),
        .i_s_tuser         (i_s_axis_tuser),
        .i_m_tvalid        (o_m_axis_tvalid),
        .i_m_tready        (i_m_axis_tready),
        .i_m_tdata         (o_m_axis_tdata),
        .i_m_tuser         (o_m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_oldest_picks    (oldest_picks),
        .o_requested_picks (requested_picks),
        .o_irq_picks       (irq_picks),
        .o_idle_picks      (idle_picks)
    );

    // result sink stalls at random each cycle
    always @(negedge i_clk) begin
        i_m_axis_tready = (sink_idle_pct == 0) || ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic logic [S_TDATA_W-1:0] pack_req(
        input logic [ID_IO_W-1:0] want,
        input logic [IDX_W-1:0]   idx,
        input logic [ID_IO_W-1:0] id,
        input logic               used,
        input logic               act,
        input logic               irq,
        input logic [STAMP_W-1:0] stamp
    );
        return {1'b0, stamp, irq, act, used, id, idx, want};
    endfunction

    // stamp that gives the wanted age at the next schedule
    function automatic logic [STAMP_W-1:0] stamp_for_age(input logic [STAMP_W-1:0] age);
        return STAMP_W'(sched_count) + 1 - age;
    endfunction

    // ids already in the table most of the time, so requests and duplicates hit
    function automatic logic [ID_IO_W-1:0] pick_id();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 9);
        w = $urandom();
        if (r < 6) return id_seen[$urandom_range(0, SLOT_COUNT_DEF - 1)];
        if (r < 8) return w[15:0];
        return ID_IO_W'($urandom_range(0, 7));
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = d;
        i_s_axis_tuser  = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        if (op == OP_SCHED) sched_count++;
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic do_sched(input logic [ID_IO_W-1:0] want);
        send_item(OP_SCHED, pack_req(want, '0, '0, 1'b0, 1'b0, 1'b0, '0));
    endtask

    task automatic do_write(
        input logic [IDX_W-1:0]   idx,
        input logic [ID_IO_W-1:0] id,
        input logic               used,
        input logic               act,
        input logic               irq,
        input logic [STAMP_W-1:0] stamp
    );
        id_seen[idx] = id;
        send_item(OP_WRITE, pack_req('0, idx, id, used, act, irq, stamp));
    endtask

    task automatic do_mark(input logic [IDX_W-1:0] idx);
        send_item(OP_MARK, pack_req('0, idx, '0, 1'b0, 1'b0, 1'b0, '0));
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        i_s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        cur_limit = v;
    endtask

    task automatic random_item();
        int                 r;
        int                 age_pick;
        logic [31:0]        w;
        logic [ID_IO_W-1:0] want;
        logic [ID_IO_W-1:0] id;
        logic [IDX_W-1:0]   idx;
        logic [STAMP_W-1:0] stamp;
        logic               used;
        logic               act;
        logic               irq;
        r        = $urandom_range(0, 99);
        w        = $urandom();
        idx      = IDX_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
        want     = pick_id();
        id       = pick_id();
        used     = ($urandom_range(0, 99) < 85);
        act      = ($urandom_range(0, 99) < 80);
        irq      = ($urandom_range(0, 1) == 1);
        age_pick = $urandom_range(0, 5);
        case (age_pick)
            0:       stamp = $urandom();
            1:       stamp = stamp_for_age(0);
            2, 3:    stamp = stamp_for_age(STAMP_W'(cur_limit) + $urandom_range(0, 4) - 2);
            4:       stamp = stamp_for_age($urandom_range(1, 64));
            default: stamp = w[0] ? '1 : '0;
        endcase
        if (r < 42) begin
            send_item(OP_SCHED, pack_req(want, idx, id, used, act, irq, stamp));
        end else if (r < 82) begin
            id_seen[idx] = id;
            send_item(OP_WRITE, pack_req(want, idx, id, used, act, irq, stamp));
        end else if (r < 96) begin
            send_item(OP_MARK, pack_req(want, idx, id, used, act, irq, stamp));
        end else begin
            send_item(OP_UNUSED, pack_req(want, idx, id, used, act, irq, stamp));
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limit [PHASES];
        int                 target;
        phase_limit[0] = 16'hFFFF;
        phase_limit[1] = 16'h0000;
        phase_limit[2] = 16'h0001;
        phase_limit[3] = LIMIT_W'($urandom_range(2, 200));
        phase_limit[4] = AGE_LIMIT_RESET;
        for (int s = 0; s < SLOT_COUNT_DEF; s++) id_seen[s] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part, age limit at its reset value
        do_sched(16'h0000);                                  // empty table
        send_item(OP_UNUSED, {1'b0, {(S_TDATA_W - 1){1'b1}}});
        do_write(4'd0, 16'h1234, 1'b1, 1'b1, 1'b1, stamp_for_age(0));
        do_mark(4'd0);
        do_sched(16'h1234);                                  // only zero age: idle
        do_write(4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        do_write(4'd7, 16'h1234, 1'b1, 1'b1, 1'b0, 32'h0000_0000);
        do_write(4'd3, 16'h0000, 1'b1, 1'b0, 1'b1, 32'h0000_0000);  // inactive
        do_write(4'd4, 16'h00AA, 1'b0, 1'b1, 1'b1, 32'h0000_0000);  // unused
        do_mark(4'd3);
        do_mark(4'd4);
        do_sched(16'h1234);                                  // fresh handler in slot 0
        do_sched(16'h1234);                                  // duplicate id, last match
        do_mark(4'd15);
        do_mark(4'd7);                                       // not a handler
        do_mark(4'd0);
        do_sched(16'hBEEF);                                  // two fresh handlers
        do_sched(16'hBEEF);
        do_write(4'd0, 16'h1234, 1'b1, 1'b1, 1'b1, 32'h8000_0000);  // running slot rewritten
        do_sched(16'hBEEF);
        do_write(4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
        do_mark(4'd15);
        do_write(4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000);  // write drops fresh mark
        do_sched(16'hFFFF);
        do_sched(16'h0000);

        target = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p]);
            src_idle_pct  = (p == 2) ? 0 : 17;
            sink_idle_pct = (p == 2) ? 0 : 17;
            target += PHASE_ITEMS;
            while (items_sent < target) random_item();
        end

        i_s_axis_tvalid = 1'b0;
        sink_idle_pct   = 17;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d requests sent (%0d schedules), %0d picks checked over five age limits",
                 items_sent, sched_count, checked);
        $display("picks: oldest %0d, requested %0d, interrupt %0d, idle %0d",
                 oldest_picks, requested_picks, irq_picks, idle_picks);
        if (fail_count == 0) begin
            $display("** oldest_first_task_picker_top: PASSED **");
        end else begin
            $display("** oldest_first_task_picker_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d picks still pending", pending);
        $display("** oldest_first_task_picker_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
design/otp_pkg.sv
design/otp_age_cmp.sv
design/otp_slot_table.sv
design/oldest_first_task_picker_top.sv
dv/otp_pick_checker.sv
dv/tb_oldest_first_task_picker_top.sv
